// ----- rtl/partitioned_multi_stack_defines.svh -----
// assertion macros shared by the partitioned multi-stack rtl
// no dependencies; included by the top level only
`ifndef PARTITIONED_MULTI_STACK_DEFINES_SVH
`define PARTITIONED_MULTI_STACK_DEFINES_SVH

// same-cycle implication, idle during reset
`define PMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked also while reset is applied
`define PMS_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pms_pkg.sv -----
// shared types, codes and constants for the partitioned multi-stack
// no dependencies; used by every rtl module of the block
package pms_pkg;

  // default sizes handed to the top level parameters
  localparam int MEM_DEPTH_DEF  = 256;
  localparam int NUM_STACKS_DEF = 4;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CAP_REGS    = 4;
  localparam int CNT_W       = 9;
  localparam int BASE_W      = 11;
  localparam int SUM_W       = 12;
  localparam int VAL_W       = 32;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [2:0] REG_STACK_COUNT = 3'd0;
  localparam logic [2:0] REG_CAP_ZERO    = 3'd1;
  localparam logic [2:0] REG_CAP_ONE     = 3'd2;
  localparam logic [2:0] REG_CAP_TWO     = 3'd3;
  localparam logic [2:0] REG_CAP_THREE   = 3'd4;

  // register reset values
  localparam logic [2:0]       STACK_COUNT_RST = 3'd4;
  localparam logic [CNT_W-1:0] CAP_RST         = 9'd64;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // value returned by a failed pop
  localparam logic signed [VAL_W-1:0] FAIL_VALUE = -32'sd1;

  typedef struct packed {
    logic                    req_type;
    logic [1:0]              stack_id;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] pop_value;
    logic                    now_full;
    logic                    now_empty;
  } out_item_t;

  // configuration seen by the front end
  typedef struct packed {
    logic [2:0]                       stack_count;
    logic [CAP_REGS-1:0][CNT_W-1:0]   cap;
  } cfg_t;

  // classified request queued between front and back
  typedef struct packed {
    logic                    req_type;
    logic [1:0]              stack_id;
    logic signed [VAL_W-1:0] push_value;
    logic                    invalid;
    logic [BASE_W-1:0]       base;
    logic [CNT_W-1:0]        cap;
  } cmd_t;

  // number of stacks that have a fill counter
  function automatic int fill_slots(input int n);
    return (n < CAP_REGS) ? n : CAP_REGS;
  endfunction

endpackage

// ----- rtl/pms_front.sv -----
// front end: takes requests, checks the stack number, looks up base and capacity
// depends on pms_pkg
module pms_front #(
  parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  pms_pkg::in_item_t  in_data,
  input  pms_pkg::cfg_t      cfg,
  input  logic               q_full,
  output logic               q_push,
  output pms_pkg::cmd_t      q_cmd
);

  localparam int NUM_FILL = pms_pkg::fill_slots(NUM_STACKS);

  logic [pms_pkg::BASE_W-1:0] base_c;
  logic                       invalid_c;

  // base is the sum of the capacities below the addressed stack
  always_comb begin
    base_c = '0;
    for (int k = 0; k < pms_pkg::CAP_REGS; k++) begin
      if (k < int'(in_data.stack_id)) begin
        base_c = base_c + pms_pkg::BASE_W'(cfg.cap[k]);
      end
    end
  end

  // stack number beyond the configured count or the built counters
  assign invalid_c = (3'(in_data.stack_id) >= cfg.stack_count) ||
                     (int'(in_data.stack_id) >= NUM_FILL);

  // queue handshake
  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

  always_comb begin
    q_cmd.req_type   = in_data.req_type;
    q_cmd.stack_id   = in_data.stack_id;
    q_cmd.push_value = in_data.push_value;
    q_cmd.invalid    = invalid_c;
    q_cmd.base       = base_c;
    q_cmd.cap        = cfg.cap[in_data.stack_id];
  end

endmodule

// ----- rtl/pms_queue.sv -----
// two-entry request queue between front end and back end
// depends on pms_pkg
module pms_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pms_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output pms_pkg::cmd_t dout,
  output logic          empty
);

  localparam int PTR_W = $clog2(pms_pkg::QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(pms_pkg::QUEUE_DEPTH + 1);

  pms_pkg::cmd_t       slot_r [pms_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_QW-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == CNT_QW'(pms_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(pms_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(pms_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/pms_back.sv -----
// back end: fill counters, address reduction, stack memory and result register
// depends on pms_pkg
module pms_back #(
  parameter int MEM_DEPTH  = pms_pkg::MEM_DEPTH_DEF,
  parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF,
  parameter int DATA_WIDTH = pms_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pms_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pms_pkg::out_item_t out_data
);

  localparam int NUM_FILL  = pms_pkg::fill_slots(NUM_STACKS);
  localparam int FI_W      = $clog2(NUM_FILL);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SW        = pms_pkg::SUM_W;
  localparam int CW        = pms_pkg::CNT_W;
  localparam int MOD_SHIFT = SW + AW + 1;
  localparam int RCP_W     = SW + 3;
  localparam int PR_W      = SW + RCP_W;
  localparam int QM_W      = SW + AW + 1;
  localparam longint unsigned RECIP =
    ((longint'(1) << MOD_SHIFT) + longint'(MEM_DEPTH) - 1) / longint'(MEM_DEPTH);
  localparam logic [31:0] MEM_LIMIT = 32'(MEM_DEPTH);

  typedef enum logic [2:0] {B_IDLE, B_EVAL, B_MUL, B_MEM, B_OUT} back_state_t;

  back_state_t                   state_r;
  pms_pkg::cmd_t                 cmd_r;
  logic [CW-1:0]                 fill_cnt_r [NUM_FILL];
  logic [SW-1:0]                 x_r;
  logic [SW-1:0]                 q_r;
  logic [1:0]                    status_r;
  logic signed [pms_pkg::VAL_W-1:0] val_r;
  logic                          nf_r;
  logic                          ne_r;
  logic                          use_rd_r;
  logic                          out_valid_r;
  pms_pkg::out_item_t            out_r;
  logic [DATA_WIDTH-1:0]         mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0]         rd_data_r;

  logic [FI_W-1:0]  idx_c;
  logic [CW-1:0]    f_c;
  logic [CW-1:0]    f_new_c;
  logic [SW-1:0]    sum_cur_c;
  logic [SW-1:0]    sum_new_c;
  logic [SW-1:0]    x_c;
  logic             full_pre_c;
  logic             full_post_c;
  logic [RCP_W-1:0] recip_c;
  logic [PR_W-1:0]  prod_c;
  logic [SW-1:0]    q_c;
  logic [QM_W-1:0]  qm_c;
  logic [SW-1:0]    r_c;
  logic [AW-1:0]    addr_c;
  logic             mem_we;
  logic             mem_re;
  logic [63:0]      wval64_c;
  logic [63:0]      rval64_c;
  logic             take_out;

  // evaluate the addressed stack before and after the request
  assign idx_c = FI_W'(cmd_r.stack_id);
  always_comb begin
    f_c        = fill_cnt_r[idx_c];
    sum_cur_c  = SW'(cmd_r.base) + SW'(f_c);
    full_pre_c = (f_c >= cmd_r.cap) || (32'(sum_cur_c) >= MEM_LIMIT);
    if (cmd_r.req_type == pms_pkg::REQ_POP) begin
      x_c       = sum_cur_c - SW'(1);
      f_new_c   = f_c - CW'(1);
      sum_new_c = x_c;
    end else begin
      x_c       = sum_cur_c;
      f_new_c   = f_c + CW'(1);
      sum_new_c = sum_cur_c + SW'(1);
    end
    full_post_c = (f_new_c >= cmd_r.cap) || (32'(sum_new_c) >= MEM_LIMIT);
  end

  // address modulo memory depth: reciprocal multiply, then back-multiply
  assign recip_c = RCP_W'(RECIP);
  assign prod_c  = PR_W'(x_r) * PR_W'(recip_c);
  assign q_c     = SW'(prod_c >> MOD_SHIFT);
  assign qm_c    = QM_W'(q_r) * QM_W'(MEM_DEPTH);
  assign r_c     = x_r - SW'(qm_c);
  assign addr_c  = AW'(r_c);

  // memory port controls and data alignment
  assign mem_we   = (state_r == B_MEM) && !use_rd_r;
  assign mem_re   = (state_r == B_MEM) && use_rd_r;
  assign wval64_c = 64'($unsigned(cmd_r.push_value));
  assign rval64_c = 64'(rd_data_r);

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign take_out  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer, fill counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_FILL; k++) begin
        fill_cnt_r[k] <= '0;
      end
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid_r && !out_stall && state_r != B_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_cmd;
            state_r <= B_EVAL;
          end
        end
        B_EVAL: begin
          use_rd_r <= 1'b0;
          priority if (cmd_r.invalid) begin
            status_r <= pms_pkg::ST_INVALID;
            val_r    <= (cmd_r.req_type == pms_pkg::REQ_POP) ? pms_pkg::FAIL_VALUE : '0;
            nf_r     <= 1'b0;
            ne_r     <= 1'b0;
            state_r  <= B_OUT;
          end else if (cmd_r.req_type == pms_pkg::REQ_PUSH && full_pre_c) begin
            status_r <= pms_pkg::ST_FULL;
            val_r    <= '0;
            nf_r     <= 1'b1;
            ne_r     <= (f_c == '0);
            state_r  <= B_OUT;
          end else if (cmd_r.req_type == pms_pkg::REQ_POP && f_c == '0) begin
            status_r <= pms_pkg::ST_EMPTY;
            val_r    <= pms_pkg::FAIL_VALUE;
            nf_r     <= full_pre_c;
            ne_r     <= 1'b1;
            state_r  <= B_OUT;
          end else begin
            status_r          <= pms_pkg::ST_OK;
            val_r             <= '0;
            nf_r              <= full_post_c;
            ne_r              <= (f_new_c == '0);
            fill_cnt_r[idx_c] <= f_new_c;
            x_r               <= x_c;
            use_rd_r          <= (cmd_r.req_type == pms_pkg::REQ_POP);
            state_r           <= B_MUL;
          end
        end
        B_MUL: begin
          q_r     <= q_c;
          state_r <= B_MEM;
        end
        B_MEM: begin
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (take_out) begin
            out_r.status    <= status_r;
            out_r.pop_value <= use_rd_r ? $signed(rval64_c[31:0]) : val_r;
            out_r.now_full  <= nf_r;
            out_r.now_empty <= ne_r;
            out_valid_r     <= 1'b1;
            state_r         <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_c] <= wval64_c[DATA_WIDTH-1:0];
    end
    if (mem_re) begin
      rd_data_r <= mem[addr_c];
    end
  end

endmodule

// ----- rtl/partitioned_multi_stack.sv -----
// Partitioned multi-stack: up to four stacks carved out of one data memory, each based at the
// sum of the capacities below it. A request is taken whenever the two-entry queue behind the
// front end has room; the back-end sequencer then handles one request at a time. A successful
// push or pop passes dequeue, evaluate, address reduction multiply, memory access and result;
// a refused or invalid request skips multiply and memory access. That loop sets the sustained
// rate. The stack memory has no clearing pass; only the fill counters are reset to zero.
// Configuration registers sit on the APB-style port and are meant to be written while idle.
//
// top level: configuration registers, front end, request queue, back end
// depends on pms_pkg, pms_front, pms_queue, pms_back, partitioned_multi_stack_defines.svh
`include "partitioned_multi_stack_defines.svh"

module partitioned_multi_stack #(
  parameter int MEM_DEPTH  = pms_pkg::MEM_DEPTH_DEF,
  parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF,
  parameter int DATA_WIDTH = pms_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pms_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pms_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pms_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [pms_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [pms_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic [2:0]                                     stack_count_r;
  logic [pms_pkg::CAP_REGS-1:0][pms_pkg::CNT_W-1:0] cap_r;
  logic [2:0]                                     reg_idx;
  logic                                           cfg_wr;
  pms_pkg::cfg_t                                  cfg;
  logic                                           q_full;
  logic                                           q_push;
  logic                                           q_empty;
  logic                                           q_pop;
  pms_pkg::cmd_t                                  q_in;
  pms_pkg::cmd_t                                  q_out;

  // register write decode
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r <= pms_pkg::STACK_COUNT_RST;
      for (int k = 0; k < pms_pkg::CAP_REGS; k++) begin
        cap_r[k] <= pms_pkg::CAP_RST;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pms_pkg::REG_STACK_COUNT: stack_count_r <= cfg_pwdata[2:0];
        pms_pkg::REG_CAP_ZERO:    cap_r[0]      <= cfg_pwdata[pms_pkg::CNT_W-1:0];
        pms_pkg::REG_CAP_ONE:     cap_r[1]      <= cfg_pwdata[pms_pkg::CNT_W-1:0];
        pms_pkg::REG_CAP_TWO:     cap_r[2]      <= cfg_pwdata[pms_pkg::CNT_W-1:0];
        pms_pkg::REG_CAP_THREE:   cap_r[3]      <= cfg_pwdata[pms_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read mux
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      pms_pkg::REG_STACK_COUNT: cfg_prdata = pms_pkg::CFG_DW'(stack_count_r);
      pms_pkg::REG_CAP_ZERO:    cfg_prdata = pms_pkg::CFG_DW'(cap_r[0]);
      pms_pkg::REG_CAP_ONE:     cfg_prdata = pms_pkg::CFG_DW'(cap_r[1]);
      pms_pkg::REG_CAP_TWO:     cfg_prdata = pms_pkg::CFG_DW'(cap_r[2]);
      pms_pkg::REG_CAP_THREE:   cfg_prdata = pms_pkg::CFG_DW'(cap_r[3]);
      default:                  cfg_prdata = '0;
    endcase
  end

  assign cfg.stack_count = stack_count_r;
  assign cfg.cap         = cap_r;

  // request classification
  pms_front #(
    .NUM_STACKS (NUM_STACKS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // decoupling queue
  pms_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // execution and result
  pms_back #(
    .MEM_DEPTH  (MEM_DEPTH),
    .NUM_STACKS (NUM_STACKS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // result consistency checks
  `PMS_ASSERT_NOW(a_invalid_flags, clk, rst_n,
    out_valid && out_data.status == pms_pkg::ST_INVALID,
    !out_data.now_full && !out_data.now_empty, "invalid stack reports full or empty")
  `PMS_ASSERT_NOW(a_empty_pop, clk, rst_n,
    out_valid && out_data.status == pms_pkg::ST_EMPTY,
    out_data.now_empty && out_data.pop_value == pms_pkg::FAIL_VALUE,
    "refused pop without empty flag or failure value")
  `PMS_ASSERT_NOW(a_full_push, clk, rst_n,
    out_valid && out_data.status == pms_pkg::ST_FULL,
    out_data.now_full && out_data.pop_value == '0, "refused push without full flag or zero value")
  `PMS_ASSERT_NEXT(a_reset_idle, clk, !rst_n, !out_valid && !in_stall,
    "block not idle after reset")

endmodule

// ----- verif/pms_checker.sv -----
// result checker for the partitioned multi-stack: mirrors the stacks and compares every result
// depends on pms_pkg; watches the request, result and register ports of the block
module pms_checker
  import pms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                pending,
  output int                ok_count,
  output int                full_count,
  output int                empty_count,
  output int                invalid_count
);

  localparam int MEM_DEPTH = MEM_DEPTH_DEF;

  // mirrored stack contents, fill counts and registers
  logic [VAL_W-1:0] stack_mirror [MEM_DEPTH];
  logic [CNT_W-1:0] fill_mirror [CAP_REGS];
  logic [CNT_W-1:0] cap_mirror [CAP_REGS];
  logic [2:0]       stack_count_mirror;

  out_item_t expected_results [$];
  out_item_t exp_res;
  out_item_t got_res;

  initial begin
    for (int k = 0; k < MEM_DEPTH; k++) stack_mirror[k] = '0;
  end

  // first entry of a stack: sum of the capacities below it
  function automatic int base_at(input logic [1:0] id);
    int sum;
    sum = 0;
    for (int k = 0; k < CAP_REGS; k++) if (k < int'(id)) sum += int'(cap_mirror[k]);
    return sum;
  endfunction

  // full by capacity or by reaching the end of the memory
  function automatic logic stack_full(input logic [1:0] id);
    return (fill_mirror[id] >= cap_mirror[id]) ||
           (base_at(id) + int'(fill_mirror[id]) >= MEM_DEPTH);
  endfunction

  // applies one request to the mirror and returns the result it must produce
  function automatic out_item_t predict_stack_op(input in_item_t req);
    out_item_t res;
    int        active;
    int        addr;
    logic [1:0] id;
    id = req.stack_id;
    active = (int'(stack_count_mirror) > CAP_REGS) ? CAP_REGS : int'(stack_count_mirror);
    res.pop_value = (req.req_type == REQ_POP) ? FAIL_VALUE : '0;
    res.now_full = 1'b0;
    res.now_empty = 1'b0;
    if (int'(id) >= active) begin
      res.status = ST_INVALID;
      return res;
    end
    if (req.req_type == REQ_PUSH) begin
      if (stack_full(id)) begin
        res.status = ST_FULL;
      end else begin
        addr = (base_at(id) + int'(fill_mirror[id])) % MEM_DEPTH;
        stack_mirror[addr] = req.push_value;
        fill_mirror[id] = fill_mirror[id] + 1'b1;
        res.status = ST_OK;
      end
    end else begin
      if (fill_mirror[id] == '0) begin
        res.status = ST_EMPTY;
      end else begin
        addr = (base_at(id) + int'(fill_mirror[id]) - 1) % MEM_DEPTH;
        res.pop_value = stack_mirror[addr];
        fill_mirror[id] = fill_mirror[id] - 1'b1;
        res.status = ST_OK;
      end
    end
    res.now_full = stack_full(id);
    res.now_empty = (fill_mirror[id] == '0);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CAP_REGS; k++) begin
        fill_mirror[k] = '0;
        cap_mirror[k] = CAP_RST;
      end
      stack_count_mirror = STACK_COUNT_RST;
      expected_results.delete();
      fail_count = 0;
      ok_count = 0;
      full_count = 0;
      empty_count = 0;
      invalid_count = 0;
    end else begin
      // register writes land at the access edge
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_STACK_COUNT: stack_count_mirror = cfg_pwdata[2:0];
          REG_CAP_ZERO:    cap_mirror[0] = cfg_pwdata[CNT_W-1:0];
          REG_CAP_ONE:     cap_mirror[1] = cfg_pwdata[CNT_W-1:0];
          REG_CAP_TWO:     cap_mirror[2] = cfg_pwdata[CNT_W-1:0];
          REG_CAP_THREE:   cap_mirror[3] = cfg_pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      // accepted request: predict and queue its result
      if (in_valid && !in_stall) begin
        exp_res = predict_stack_op(in_data);
        expected_results.push_back(exp_res);
        case (exp_res.status)
          ST_OK:    ok_count++;
          ST_FULL:  full_count++;
          ST_EMPTY: empty_count++;
          default:  invalid_count++;
        endcase
      end

      // accepted result: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        got_res = out_data;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", got_res);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got_res.status !== exp_res.status) begin
            $error("field status: expected %0d, actual %0d", exp_res.status, got_res.status);
            fail_count++;
          end
          if (got_res.pop_value !== exp_res.pop_value) begin
            $error("field pop_value: expected %0d, actual %0d",
                   exp_res.pop_value, got_res.pop_value);
            fail_count++;
          end
          if (got_res.now_full !== exp_res.now_full) begin
            $error("field now_full: expected %0d, actual %0d",
                   exp_res.now_full, got_res.now_full);
            fail_count++;
          end
          if (got_res.now_empty !== exp_res.now_empty) begin
            $error("field now_empty: expected %0d, actual %0d",
                   exp_res.now_empty, got_res.now_empty);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- verif/partitioned_multi_stack_tb.sv -----
// top of the partitioned multi-stack testbench: clock, reset, requests, registers and verdict
// depends on pms_pkg, the partitioned_multi_stack rtl and pms_checker
module partitioned_multi_stack_tb;
  import pms_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int FILL_PUSHES     = 66;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int   fail_count;
  int   pending;
  int   ok_count;
  int   full_count;
  int   empty_count;
  int   invalid_count;
  int   config_count = 0;
  logic hold_off_req = 1'b0;

  partitioned_multi_stack uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  pms_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .ok_count     (ok_count),
    .full_count   (full_count),
    .empty_count  (empty_count),
    .invalid_count(invalid_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

  // result side: changing stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    int hold_left;
    logic hold_done;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ((left % 5) < 2);
        endcase
      end
    end
  end

  // value to push, with the extremes mixed in
  function automatic logic [VAL_W-1:0] pick_push_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // offer one request and hold it until accepted
  task automatic send_req(input logic kind, input logic [1:0] id, input logic [VAL_W-1:0] value);
    in_item_t req;
    logic     stalled;
    req.req_type = kind;
    req.stack_id = id;
    req.push_value = value;
    in_valid <= 1'b1;
    in_data <= req;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // wait for every outstanding result, then let the back end go quiet
  task automatic settle();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
  endtask

  // write all registers while the block is idle
  task automatic apply_config(input int count, input int c0, input int c1, input int c2,
                              input int c3);
    settle();
    write_reg(REG_STACK_COUNT, count);
    write_reg(REG_CAP_ZERO, c0);
    write_reg(REG_CAP_ONE, c1);
    write_reg(REG_CAP_TWO, c2);
    write_reg(REG_CAP_THREE, c3);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    config_count++;
  endtask

  // random requests in bursts; at least half go to a favored stack to reach full and empty
  task automatic run_mix(input int n, input int push_pct, input logic [1:0] hot);
    int         sent;
    int         burst;
    int         gap;
    int         k;
    logic       kind;
    logic [1:0] id;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < n; k++) begin
        kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        id = ($urandom_range(0, 1) == 1) ? hot : 2'($urandom_range(0, 3));
        send_req(kind, id, pick_push_value());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && sent < n) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    int s;
    int j;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tiny stacks, a zero-capacity stack and an unused stack
    apply_config(3, 2, 0, 3, 64);
    send_req(REQ_PUSH, 2'd0, 32'h7fff_ffff);
    send_req(REQ_PUSH, 2'd0, 32'h8000_0000);
    send_req(REQ_PUSH, 2'd0, 32'd5);          // push onto a full stack
    send_req(REQ_POP,  2'd0, 32'd0);
    send_req(REQ_POP,  2'd0, 32'hffff_ffff);
    send_req(REQ_POP,  2'd0, 32'd0);          // pop from an empty stack
    send_req(REQ_PUSH, 2'd1, 32'd0);          // zero capacity: full and empty at once
    send_req(REQ_POP,  2'd1, 32'd7);
    send_req(REQ_PUSH, 2'd2, 32'hffff_ffff);
    send_req(REQ_PUSH, 2'd2, 32'd0);
    send_req(REQ_POP,  2'd2, 32'd0);
    send_req(REQ_POP,  2'd2, 32'd0);
    send_req(REQ_PUSH, 2'd3, 32'd123);        // stack beyond the configured count
    send_req(REQ_POP,  2'd3, 32'd0);
    send_req(REQ_PUSH, 2'd2, pick_push_value());
    send_req(REQ_POP,  2'd2, pick_push_value());
    in_valid <= 1'b0;

    // fill every stack past its capacity so that the whole memory holds written data
    apply_config(4, 64, 64, 64, 64);
    for (s = 0; s < CAP_REGS; s++)
      for (j = 0; j < FILL_PUSHES; j++) send_req(REQ_PUSH, 2'(s), pick_push_value());
    in_valid <= 1'b0;

    // random phases over a range of settings; fill counts carry across them
    settle();
    hold_off_req <= 1'b1;
    run_mix(120, 45, 2'd1);
    apply_config(1, 64, 64, 64, 64);
    run_mix(120, 50, 2'd0);
    apply_config(0, 64, 64, 64, 64);
    run_mix(60, 50, 2'd2);
    apply_config(7, 256, 256, 256, 256);
    run_mix(140, 75, 2'd0);
    apply_config(4, 0, 0, 0, 0);
    run_mix(120, 30, 2'd3);
    apply_config(4, 511, 511, 511, 511);
    run_mix(130, 65, 2'd1);
    apply_config(4, 250, 3, 3, 3);
    run_mix(130, 70, 2'd2);
    repeat (2) begin
      apply_config($urandom_range(0, 7), $urandom_range(0, 511), $urandom_range(0, 511),
                   $urandom_range(0, 511), $urandom_range(0, 511));
      run_mix(110, $urandom_range(20, 80), 2'($urandom_range(0, 3)));
    end
    apply_config(4, 64, 64, 64, 64);
    run_mix(140, 20, 2'd0);

    settle();
    $display("covered %0d requests: %0d completed, %0d refused full, %0d refused empty,",
             ok_count + full_count + empty_count + invalid_count, ok_count, full_count,
             empty_count);
    $display("%0d to unused stacks, across %0d register settings, with one %0d-cycle hold-off",
             invalid_count, config_count, HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
